>>> hw/rtl/i2c_master_bit_engine_top_defines.svh
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// check macros used by the bit engine phase sequencer
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define I2CBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2c bit engine check failed");

// next-cycle implication, disabled while in reset
`define I2CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2c bit engine check failed");

`endif

>>> hw/rtl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// types, constants and the phase table of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cbe_pkg;

	// command queue between front and back
	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);

	// phase buffer in front of the result port
	localparam int OUT_BUF_DEPTH = 2;
	localparam int OUT_PTR_W     = $clog2(OUT_BUF_DEPTH);

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

	// bus command codes as seen on the input
	localparam logic [2:0] FUNC_START = 3'd0;
	localparam logic [2:0] FUNC_STOP  = 3'd1;
	localparam logic [2:0] FUNC_WRITE = 3'd2;
	localparam logic [2:0] FUNC_READ  = 3'd3;
	localparam logic [2:0] FUNC_CHECK = 3'd4;
	localparam logic [2:0] FUNC_ACK   = 3'd5;
	localparam logic [2:0] FUNC_NACK  = 3'd6;

	typedef enum logic [2:0] {
		K_START = 3'd0,
		K_STOP  = 3'd1,
		K_WRITE = 3'd2,
		K_READ  = 3'd3,
		K_CHECK = 3'd4,
		K_ACK   = 3'd5,
		K_NACK  = 3'd6
	} kind_t;

	// classified command carried through the queue
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} cmd_t;

	// one emitted pin phase
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       nack;
		logic [7:0] rb;
		logic       last;
	} res_t;

	// pin levels of phase idx of a command, given the current scl level
	function automatic res_t phase_f(kind_t kind, logic [3:0] idx, logic scl_cur,
		logic [7:0] data);
		res_t p;
		logic bit_v;
		p.scl  = scl_cur;
		p.sda  = 1'b1;
		p.drv  = 1'b1;
		p.nack = 1'b0;
		p.rb   = 8'h00;
		p.last = 1'b0;
		bit_v  = data[3'd7 - idx[3:1]];
		case (kind)
			K_START: begin
				case (idx)
					4'd0: p.scl = scl_cur;
					4'd1: p.scl = 1'b1;
					4'd2: begin
						p.scl = 1'b1;
						p.sda = 1'b0;
					end
					default: begin
						p.scl  = 1'b0;
						p.sda  = 1'b0;
						p.last = 1'b1;
					end
				endcase
			end
			K_STOP: begin
				case (idx)
					4'd0: begin
						p.scl = scl_cur;
						p.sda = 1'b0;
					end
					4'd1: begin
						p.scl = 1'b1;
						p.sda = 1'b0;
					end
					default: begin
						p.scl  = 1'b1;
						p.last = 1'b1;
					end
				endcase
			end
			K_WRITE: begin
				p.scl  = ~idx[0];
				p.sda  = bit_v;
				p.last = (idx == 4'd15);
			end
			K_READ: begin
				p.scl  = ~idx[0];
				p.drv  = 1'b0;
				p.last = (idx == 4'd15);
				p.rb   = (idx == 4'd15) ? data : 8'h00;
			end
			K_CHECK: begin
				case (idx)
					4'd0: p.scl = scl_cur;
					4'd1: p.scl = 1'b1;
					default: begin
						// ack low pulls scl low, no ack leaves it high
						p.scl  = data[0];
						p.drv  = 1'b0;
						p.nack = data[0];
						p.last = 1'b1;
					end
				endcase
			end
			K_ACK, K_NACK: begin
				p.sda = (kind == K_NACK);
				case (idx)
					4'd0: p.scl = scl_cur;
					4'd1: p.scl = 1'b1;
					default: begin
						p.scl  = 1'b0;
						p.last = 1'b1;
					end
				endcase
			end
			default: p.last = 1'b1;
		endcase
		return p;
	endfunction

endpackage

>>> hw/rtl/i2cbe_front.sv
// ----------------------------------------------------------------------------
// i2cbe_front
// accepts bus commands, classifies them and drops unused codes
// ----------------------------------------------------------------------------
module i2cbe_front import i2cbe_pkg::*; (
	input  logic       push,
	output logic       full,
	input  logic [2:0] func,
	input  logic [7:0] write_byte,
	input  logic [7:0] sda_samples,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic legal;

	// decode command code and pick the data byte it needs
	always_comb begin
		legal        = 1'b1;
		q_cmd.kind   = K_START;
		q_cmd.data   = 8'h00;
		case (func)
			FUNC_START: q_cmd.kind = K_START;
			FUNC_STOP:  q_cmd.kind = K_STOP;
			FUNC_WRITE: begin
				q_cmd.kind = K_WRITE;
				q_cmd.data = write_byte;
			end
			FUNC_READ: begin
				q_cmd.kind = K_READ;
				q_cmd.data = sda_samples;
			end
			FUNC_CHECK: begin
				q_cmd.kind = K_CHECK;
				q_cmd.data = sda_samples;
			end
			FUNC_ACK:   q_cmd.kind = K_ACK;
			FUNC_NACK:  q_cmd.kind = K_NACK;
			default:    legal = 1'b0;
		endcase
	end

	// unused code is taken and discarded without a phase
	assign full   = q_full;
	assign q_push = push && !q_full && legal;

endmodule

>>> hw/rtl/i2cbe_cmd_queue.sv
// ----------------------------------------------------------------------------
// i2cbe_cmd_queue
// short command queue between the front and the phase sequencer
// ----------------------------------------------------------------------------
module i2cbe_cmd_queue import i2cbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t                 entries_q [CMD_QUEUE_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == (CMD_PTR_W+1)'(CMD_QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/i2cbe_back.sv
// ----------------------------------------------------------------------------
// i2cbe_back
// phase sequencer: steps through each command's pin phases and paces them
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_top_defines.svh"

module i2cbe_back import i2cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] half_period_ticks,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output res_t        res
);

	logic [15:0]          half_period_q;
	logic [15:0]          timer_q;
	logic                 busy_q;
	cmd_t                 cmd_q;
	logic [3:0]           idx_q;
	logic                 scl_q;
	res_t                 ph;
	logic                 can_emit;
	logic                 fetch;
	res_t                 ob_q [OUT_BUF_DEPTH];
	logic [OUT_PTR_W-1:0] ob_wr_q;
	logic [OUT_PTR_W-1:0] ob_rd_q;
	logic [OUT_PTR_W:0]   ob_cnt_q;
	logic                 ob_full;
	logic                 ob_pop;

	// half period register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			half_period_q <= half_period_ticks;
		end
	end

	// current phase and stepping conditions
	assign ph       = phase_f(cmd_q.kind, idx_q, scl_q, cmd_q.data);
	assign ob_full  = (ob_cnt_q == (OUT_PTR_W+1)'(OUT_BUF_DEPTH));
	assign can_emit = busy_q && (timer_q == '0) && !ob_full;
	assign fetch    = !q_empty && (!busy_q || (can_emit && ph.last));
	assign q_pop    = fetch;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			scl_q   <= 1'b1;
			timer_q <= '0;
		end else begin
			if (fetch) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (can_emit && ph.last) begin
				busy_q <= 1'b0;
			end else if (can_emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (can_emit) begin
				scl_q   <= ph.scl;
				timer_q <= (half_period_q > 16'd1) ? (half_period_q - 16'd1) : '0;
			end else if (timer_q != '0) begin
				timer_q <= timer_q - 16'd1;
			end
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (fetch) begin
			cmd_q <= q_cmd;
		end
	end

	// phase buffer toward the result port
	assign empty  = (ob_cnt_q == '0);
	assign ob_pop = pop && !empty;
	assign res    = ob_q[ob_rd_q];

	always_ff @(posedge clk) begin
		if (can_emit) begin
			ob_q[ob_wr_q] <= ph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= '0;
			ob_rd_q  <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (can_emit) begin
				ob_wr_q <= ob_wr_q + 1'b1;
			end
			if (ob_pop) begin
				ob_rd_q <= ob_rd_q + 1'b1;
			end
			case ({can_emit, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 1'b1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 1'b1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

	// checks
	`I2CBE_ASSERT_NOW(a_ob_bound, clk, arst_n, 1'b1, ob_cnt_q <= (OUT_PTR_W+1)'(OUT_BUF_DEPTH))
	`I2CBE_ASSERT_NEXT(a_run_continues, clk, arst_n, can_emit && !ph.last, busy_q)
	`I2CBE_ASSERT_NOW(a_short_run, clk, arst_n, busy_q && cmd_q.kind != K_WRITE && cmd_q.kind != K_READ, idx_q <= 4'd3)
	`I2CBE_ASSERT_NEXT(a_hold_phase, clk, arst_n, can_emit && half_period_q > 16'd1, timer_q != '0)

endmodule

>>> hw/rtl/i2c_master_bit_engine_top.sv
// a command reaches the result ports via the command queue, cmd_q and the phase buffer
// phases are paced by the phase hold timer and wait while the phase buffer is full
// a byte command emits 16 phases, start 4, all others 3; unused code 7 emits none
// a command that finds the sequencer idle is fetched before its first phase is built
// reset: scl high, command queue and phase buffer empty, half period 100
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// i2c master bit engine: bus commands in, paced scl/sda pin phases out
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top import i2cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] half_period_ticks,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  func,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  sda_samples,
	output logic        empty,
	input  logic        pop,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic        nack_seen,
	output logic [7:0]  read_byte,
	output logic        last
);

	logic q_full;
	logic q_push;
	cmd_t q_wcmd;
	logic q_pop;
	cmd_t q_rcmd;
	logic q_empty;
	res_t res;

	// command decode
	i2cbe_front u_front (
		.push        (push),
		.full        (full),
		.func        (func),
		.write_byte  (write_byte),
		.sda_samples (sda_samples),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_wcmd)
	);

	// queue between decode and sequencer
	i2cbe_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wcmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rcmd),
		.empty  (q_empty)
	);

	// phase sequencer and result buffer
	i2cbe_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.half_period_ticks (half_period_ticks),
		.q_empty           (q_empty),
		.q_cmd             (q_rcmd),
		.q_pop             (q_pop),
		.pop               (pop),
		.empty             (empty),
		.res               (res)
	);

	// result fields
	assign scl_level = res.scl;
	assign sda_level = res.sda;
	assign sda_drive = res.drv;
	assign nack_seen = res.nack;
	assign read_byte = res.rb;
	assign last      = res.last;

endmodule
